// ===== rtl/cs3_pkg.sv =====
package cs3_pkg;

   localparam int SAMPLE_W = 32;
   localparam int CNT_W    = 8;
   localparam int C20_W    = 37;   // 20 * sample
   localparam int SUM4_W   = 34;   // sum of four samples
   localparam int N_W      = 37;   // weighted stencil sum
   localparam int Y_W      = 33;   // rounded magnitude / 4, when not saturating

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   localparam logic [CNT_W-1:0] REG_INTERIOR_COLS = 8'd0;
   localparam logic [CNT_W-1:0] REG_INTERIOR_ROWS = 8'd1;
   localparam logic [CNT_W-1:0] REG_RESET_VALUE   = 8'd254;

   // divide by 3 through reciprocals: ceil(2^17/3) and ceil(2^20/3)
   localparam logic [16:0] RECIP_HI   = 17'd43691;
   localparam logic [19:0] RECIP_LO   = 20'd349526;
   localparam logic [N_W-1:0] ROUND_BIAS = 37'd6;
   // (mag+6)/4 thresholds at or above which the quotient by 3 overflows
   localparam logic [34:0] SAT_POS_Y = 35'd6442450944;
   localparam logic [34:0] SAT_NEG_Y = 35'd6442450947;
   localparam logic [SAMPLE_W-1:0] SAT_POS_VAL = 32'h7FFF_FFFF;
   localparam logic [SAMPLE_W-1:0] SAT_NEG_VAL = 32'h8000_0000;

   typedef struct packed {
      logic produce;
      logic last;
   } tag_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] middle;
      logic [SAMPLE_W-1:0] upper;
   } line_word_type;

   typedef struct packed {
      logic signed [C20_W-1:0]  c20;
      logic signed [SUM4_W-1:0] corners;
      logic signed [SUM4_W-1:0] sides;
      logic                     last;
   } sums_type;

endpackage

// ===== rtl/compensator_stencil_3x3_unit.sv =====
// 3x3 compensator stencil over a raster stream with a one-cell halo.
// Throughput: one sample beat per cycle while the result stream does not
// stall; halo samples give no result beat. Path from a taken sample beat
// to its result: line store read on the accept edge, window sum register,
// six-stage round / divide-by-12. Reset: counters, window registers and
// pipeline valids clear; the line store is not cleared, entries in use are
// rewritten in the first two rows of every frame.
module compensator_stencil_3x3_unit #(
   parameter int MAX_WIDTH  = cs3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = cs3_pkg::MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] filtered
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam int AddrW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ColsLimInt  = (MAX_WIDTH - 2 < 254) ? MAX_WIDTH - 2 : 254;
   localparam int RowsLimInt  = (MAX_HEIGHT - 2 < 254) ? MAX_HEIGHT - 2 : 254;
   localparam logic [cs3_pkg::CNT_W-1:0] ColsLim = cs3_pkg::CNT_W'(ColsLimInt);
   localparam logic [cs3_pkg::CNT_W-1:0] RowsLim = cs3_pkg::CNT_W'(RowsLimInt);

   function automatic logic [7:0] clamp_reg(input logic [7:0] v, input logic [7:0] lim);
      logic [7:0] x;
      x = v;
      if (x < 8'd1) x = 8'd1;
      if (x > lim) x = lim;
      return x;
   endfunction

   logic [cs3_pkg::CNT_W-1:0] cols_ff, rows_ff;
   logic [cs3_pkg::CNT_W-1:0] col_cnt_ff, row_cnt_ff;
   logic [cs3_pkg::CNT_W-1:0] col_cnt_in, row_cnt_in;

   logic                      s1_vld_ff;
   cs3_pkg::tag_type          s1_tag_ff;
   cs3_pkg::tag_type          s0_tag;
   logic [AddrW-1:0]          s1_addr_ff;
   logic [31:0]               s1_bot_ff;

   logic                      accept;
   logic                      s1_move;
   logic                      div_ready;
   logic                      cfg_hit;
   logic                      col_end, row_end;
   cs3_pkg::line_word_type    rd_word;
   cs3_pkg::line_word_type    wr_word;
   cs3_pkg::sums_type         sums;

   assign csr_ready = 1'b1;
   assign cfg_hit   = csr_valid & csr_ready
                    & ((csr_index == cs3_pkg::REG_INTERIOR_COLS)
                     | (csr_index == cs3_pkg::REG_INTERIOR_ROWS));

   assign accept     = req_tvalid & req_tready;
   assign s1_move    = s1_vld_ff & (~s1_tag_ff.produce | div_ready);
   assign req_tready = ~s1_vld_ff | s1_move;

   always_comb begin
      col_end        = {1'b0, col_cnt_ff} >= ({1'b0, cols_ff} + 9'd1);
      row_end        = {1'b0, row_cnt_ff} >= ({1'b0, rows_ff} + 9'd1);
      s0_tag.produce = (row_cnt_ff >= 8'd2) && (col_cnt_ff >= 8'd2);
      s0_tag.last    = ({1'b0, col_cnt_ff} == ({1'b0, cols_ff} + 9'd1))
                    && ({1'b0, row_cnt_ff} == ({1'b0, rows_ff} + 9'd1));

      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (cfg_hit) begin
         col_cnt_in = '0;
         row_cnt_in = '0;
      end else if (accept) begin
         if (col_end) begin
            col_cnt_in = '0;
            row_cnt_in = row_end ? '0 : row_cnt_ff + 8'd1;
         end else begin
            col_cnt_in = col_cnt_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff    <= clamp_reg(cs3_pkg::REG_RESET_VALUE, ColsLim);
         rows_ff    <= clamp_reg(cs3_pkg::REG_RESET_VALUE, RowsLim);
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         s1_vld_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready && csr_index == cs3_pkg::REG_INTERIOR_COLS) begin
            cols_ff <= clamp_reg(csr_data, ColsLim);
         end
         if (csr_valid && csr_ready && csr_index == cs3_pkg::REG_INTERIOR_ROWS) begin
            rows_ff <= clamp_reg(csr_data, RowsLim);
         end
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
         if (req_tready) s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tag_ff  <= s0_tag;
         s1_addr_ff <= AddrW'(col_cnt_ff);
         s1_bot_ff  <= req_tdata;
      end
   end

   // upper gets the old middle row, middle gets the incoming sample
   assign wr_word.upper  = rd_word.middle;
   assign wr_word.middle = s1_bot_ff;

   cs3_line_mem #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (AddrW)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (AddrW'(col_cnt_ff)),
      .rd_data (rd_word),
      .wr_en   (s1_move),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_word)
   );

   cs3_window u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_move),
      .top      (rd_word.upper),
      .mid      (rd_word.middle),
      .bot      (s1_bot_ff),
      .last     (s1_tag_ff.last),
      .sums     (sums)
   );

   cs3_round_div u_round_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_vld_ff & s1_tag_ff.produce),
      .in_ready  (div_ready),
      .in_sums   (sums),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (rsp_tdata),
      .out_last  (rsp_tlast)
   );

   a_col_bound : assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_cnt_ff} <= ({1'b0, cols_ff} + 9'd1))
      else $error("column counter past frame width");

   a_row_bound : assert property (@(posedge clock) disable iff (reset)
      {1'b0, row_cnt_ff} <= ({1'b0, rows_ff} + 9'd1))
      else $error("row counter past frame height");

   a_frame_wrap : assert property (@(posedge clock) disable iff (reset)
      (accept && s0_tag.last) |=> (col_cnt_ff == '0 && row_cnt_ff == '0))
      else $error("counters did not wrap after last frame beat");

   a_s1_fill : assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_vld_ff)
      else $error("accepted beat missing from line store stage");

endmodule

// ===== rtl/cs3_line_mem.sv =====
module cs3_line_mem #(
   parameter int DEPTH  = cs3_pkg::MAX_WIDTH_DEF,
   parameter int ADDR_W = 8
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output cs3_pkg::line_word_type rd_data,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  cs3_pkg::line_word_type wr_data
);

   cs3_pkg::line_word_type mem_ff [DEPTH];
   cs3_pkg::line_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cs3_window.sv =====
module cs3_window (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift_en,
   input  logic signed [31:0]     top,
   input  logic signed [31:0]     mid,
   input  logic signed [31:0]     bot,
   input  logic                   last,
   output cs3_pkg::sums_type      sums
);

   // columns c-2 (0..2) and c-1 (3..5), each top/mid/bot
   logic signed [cs3_pkg::SAMPLE_W-1:0] window_ff [6];
   logic signed [cs3_pkg::C20_W-1:0]    centre_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            window_ff[i] <= '0;
         end
      end else if (shift_en) begin
         window_ff[0] <= window_ff[3];
         window_ff[1] <= window_ff[4];
         window_ff[2] <= window_ff[5];
         window_ff[3] <= top;
         window_ff[4] <= mid;
         window_ff[5] <= bot;
      end
   end

   always_comb begin
      centre_ext   = {{5{window_ff[4][31]}}, window_ff[4]};
      sums.c20     = (centre_ext <<< 4) + (centre_ext <<< 2);
      sums.corners = {{2{window_ff[0][31]}}, window_ff[0]}
                   + {{2{window_ff[2][31]}}, window_ff[2]}
                   + {{2{top[31]}}, top}
                   + {{2{bot[31]}}, bot};
      sums.sides   = {{2{window_ff[1][31]}}, window_ff[1]}
                   + {{2{window_ff[3][31]}}, window_ff[3]}
                   + {{2{window_ff[5][31]}}, window_ff[5]}
                   + {{2{mid[31]}}, mid};
      sums.last    = last;
   end

endmodule

// ===== rtl/cs3_round_div.sv =====
module cs3_round_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  cs3_pkg::sums_type   in_sums,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [31:0]         out_value,
   output logic                out_last
);

   localparam int NST = 7;

   typedef struct packed {
      logic neg;
      logic sat;
      logic last;
   } flags_type;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] load;

   cs3_pkg::sums_type                s0_ff;
   logic signed [cs3_pkg::N_W-1:0]   n_ff;
   logic                             n_last_ff;
   logic [cs3_pkg::Y_W-1:0]          y_ff;
   flags_type                        f2_ff, f3_ff, f4_ff, f5_ff;
   logic [15:0]                      qh3_ff, qh4_ff, qh5_ff;
   logic [15:0]                      yh3_ff;
   logic [16:0]                      yl3_ff;
   logic [18:0]                      t_ff;
   logic [16:0]                      qt_ff;
   logic [31:0]                      value_ff;
   logic                             last_ff;

   logic signed [cs3_pkg::N_W-1:0]   n_in;
   logic [cs3_pkg::N_W-1:0]          mag;
   logic [cs3_pkg::N_W-1:0]          biased;
   logic [34:0]                      y_full;
   flags_type                        f2_in;
   logic [32:0]                      prod_h;
   logic [15:0]                      rh_full;
   logic [38:0]                      prod_t;
   logic [31:0]                      q;
   logic [31:0]                      value_in;

   always_comb begin
      load[NST-1] = ~vld_ff[NST-1] | out_ready;
      for (int i = NST - 2; i >= 0; i--) begin
         load[i] = ~vld_ff[i] | load[i+1];
      end
   end

   assign in_ready = load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (load[0]) vld_ff[0] <= in_valid;
         for (int i = 1; i < NST; i++) begin
            if (load[i]) vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_comb begin
      n_in = s0_ff.c20
           - {{3{s0_ff.corners[cs3_pkg::SUM4_W-1]}}, s0_ff.corners}
           - {{3{s0_ff.sides[cs3_pkg::SUM4_W-1]}}, s0_ff.sides};

      // round half away from zero on the magnitude: (|n| + 6) / 12
      f2_in.neg  = n_ff[cs3_pkg::N_W-1];
      mag        = f2_in.neg ? (cs3_pkg::N_W'(0) - n_ff) : n_ff;
      biased     = mag + cs3_pkg::ROUND_BIAS;
      y_full     = biased[36:2];
      f2_in.sat  = f2_in.neg ? (y_full >= cs3_pkg::SAT_NEG_Y) : (y_full >= cs3_pkg::SAT_POS_Y);
      f2_in.last = n_last_ff;

      // y / 3 split as high 16 bits and low 17 bits
      prod_h  = 33'(y_ff[32:17]) * 33'(cs3_pkg::RECIP_HI);
      rh_full = yh3_ff - ((qh3_ff << 1) + qh3_ff);
      prod_t  = 39'(t_ff) * 39'(cs3_pkg::RECIP_LO);

      q = {qh5_ff[14:0], qt_ff};
      if (f5_ff.sat) begin
         value_in = f5_ff.neg ? cs3_pkg::SAT_NEG_VAL : cs3_pkg::SAT_POS_VAL;
      end else begin
         value_in = f5_ff.neg ? (32'd0 - q) : q;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) s0_ff <= in_sums;
      if (load[1]) begin
         n_ff      <= n_in;
         n_last_ff <= s0_ff.last;
      end
      if (load[2]) begin
         y_ff  <= y_full[32:0];
         f2_ff <= f2_in;
      end
      if (load[3]) begin
         qh3_ff <= prod_h[32:17];
         yh3_ff <= y_ff[32:17];
         yl3_ff <= y_ff[16:0];
         f3_ff  <= f2_ff;
      end
      if (load[4]) begin
         t_ff   <= {rh_full[1:0], yl3_ff};
         qh4_ff <= qh3_ff;
         f4_ff  <= f3_ff;
      end
      if (load[5]) begin
         qt_ff  <= prod_t[36:20];
         qh5_ff <= qh4_ff;
         f5_ff  <= f4_ff;
      end
      if (load[6]) begin
         value_ff <= value_in;
         last_ff  <= f5_ff.last;
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_value = value_ff;
   assign out_last  = last_ff;

endmodule
